// ----- hdl/jsu_pkg.sv -----
package jsu_pkg;

  // Parsing phase of the front end.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  // Result status codes as they appear on the output.
  typedef enum logic [2:0] {
    ST_BYTE   = 3'd0,
    ST_DONE   = 3'd1,
    ST_QUOTE  = 3'd2,
    ST_BADESC = 3'd3,
    ST_SHORTU = 3'd4,
    ST_BADHEX = 3'd5,
    ST_UNKESC = 3'd6,
    ST_UNTERM = 3'd7
  } status_t;

  // One decoded request: up to three data bytes followed by an optional
  // status result. At least one of the two is present in a queued job.
  typedef struct packed {
    logic [1:0] nbytes;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       has_tail;
    status_t    tail;
  } job_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U = 8'h75;

endpackage

// ----- hdl/jsu_front.sv -----
module jsu_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     text_byte,
  input  logic [2:0]     bytes_after,
  output logic           job_valid,
  output jsu_pkg::job_t  job
);
  import jsu_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hex_count_r, hex_count_nxt;
  logic [15:0] code_r, code_nxt;

  logic        last;
  logic        is_hex;
  logic [3:0]  hex_d;
  logic        is_simple;
  logic [7:0]  simple_b;
  logic [15:0] code_full;

  assign last = (bytes_after == 3'd0);
  assign code_full = {code_r[11:0], hex_d};

  always_comb begin
    is_hex = 1'b1;
    hex_d  = 4'd0;
    if (text_byte inside {[8'h30:8'h39]}) begin
      hex_d = text_byte[3:0];
    end else if (text_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hex_d = text_byte[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    is_simple = 1'b1;
    simple_b  = text_byte;
    case (text_byte)
      8'h22, 8'h5C, 8'h2F: simple_b = text_byte;
      8'h62: simple_b = 8'h08;
      8'h66: simple_b = 8'h0C;
      8'h6E: simple_b = 8'h0A;
      8'h72: simple_b = 8'h0D;
      8'h74: simple_b = 8'h09;
      default: is_simple = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    phase_nxt     = phase_r;
    hex_count_nxt = hex_count_r;
    code_nxt      = code_r;
    case (phase_r)
      PH_STR: begin
        if (text_byte == CH_QUOTE) begin
          phase_nxt = PH_IDLE;
        end else if (text_byte == CH_BSLASH) begin
          phase_nxt = last ? PH_IDLE : PH_ESC;
        end else if (last) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_ESC: begin
        if (is_simple) begin
          phase_nxt = last ? PH_IDLE : PH_STR;
        end else if (text_byte == CH_U && bytes_after >= 3'd4) begin
          phase_nxt     = PH_HEX;
          hex_count_nxt = 2'd0;
          code_nxt      = 16'd0;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_HEX: begin
        if (!is_hex) begin
          phase_nxt = PH_IDLE;
        end else if (hex_count_r != 2'd3) begin
          code_nxt = code_full;
          if (last) begin
            phase_nxt = PH_IDLE;
          end else begin
            hex_count_nxt = hex_count_r + 2'd1;
          end
        end else begin
          code_nxt      = 16'd0;
          hex_count_nxt = 2'd0;
          phase_nxt     = last ? PH_IDLE : PH_STR;
        end
      end
      default: begin
        if (text_byte == CH_QUOTE && !last) begin
          phase_nxt = PH_STR;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase
  end

  // Job produced by the current byte.
  always_comb begin
    job          = '0;
    job.tail     = ST_BYTE;
    case (phase_r)
      PH_STR: begin
        if (text_byte == CH_QUOTE) begin
          job.has_tail = 1'b1;
          job.tail     = ST_DONE;
        end else if (text_byte == CH_BSLASH) begin
          job.has_tail = last;
          job.tail     = ST_BADESC;
        end else begin
          job.nbytes   = 2'd1;
          job.b0       = text_byte;
          job.has_tail = last;
          job.tail     = ST_UNTERM;
        end
      end
      PH_ESC: begin
        if (is_simple) begin
          job.nbytes   = 2'd1;
          job.b0       = simple_b;
          job.has_tail = last;
          job.tail     = ST_UNTERM;
        end else if (text_byte == CH_U) begin
          job.has_tail = (bytes_after < 3'd4);
          job.tail     = ST_SHORTU;
        end else begin
          job.has_tail = 1'b1;
          job.tail     = ST_UNKESC;
        end
      end
      PH_HEX: begin
        if (!is_hex) begin
          job.has_tail = 1'b1;
          job.tail     = ST_BADHEX;
        end else if (hex_count_r != 2'd3) begin
          job.has_tail = last;
          job.tail     = ST_SHORTU;
        end else begin
          job.has_tail = last;
          job.tail     = ST_UNTERM;
          if (code_full[15:7] == 9'd0) begin
            job.nbytes = 2'd1;
            job.b0     = {1'b0, code_full[6:0]};
          end else if (code_full[15:11] == 5'd0) begin
            job.nbytes = 2'd2;
            job.b0     = {3'b110, code_full[10:6]};
            job.b1     = {2'b10, code_full[5:0]};
          end else begin
            job.nbytes = 2'd3;
            job.b0     = {4'b1110, code_full[15:12]};
            job.b1     = {2'b10, code_full[11:6]};
            job.b2     = {2'b10, code_full[5:0]};
          end
        end
      end
      default: begin
        if (text_byte == CH_QUOTE) begin
          job.has_tail = last;
          job.tail     = ST_UNTERM;
        end else begin
          job.has_tail = 1'b1;
          job.tail     = ST_QUOTE;
        end
      end
    endcase
  end

  assign job_valid = accept && (job.has_tail || (job.nbytes != 2'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      hex_count_r <= 2'd0;
      code_r      <= 16'd0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      hex_count_r <= hex_count_nxt;
      code_r      <= code_nxt;
    end
  end

endmodule

// ----- hdl/jsu_queue.sv -----
module jsu_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jsu_pkg::job_t  push_job,
  input  logic           pop,
  output jsu_pkg::job_t  head_job,
  output logic           empty,
  output logic           full
);
  import jsu_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hdl/jsu_back.sv -----
module jsu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  jsu_pkg::job_t  head_job,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic [2:0]     out_status,
  output logic           out_run_last
);
  import jsu_pkg::*;

  logic [1:0] sub_r, sub_nxt;
  logic       valid_r;
  logic [7:0] byte_r, byte_nxt;
  status_t    status_r, status_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic [2:0] total;

  assign total = {1'b0, head_job.nbytes} + {2'b00, head_job.has_tail};
  assign load  = !valid_r || !out_stall;

  // Select the result at the current position within the head job.
  always_comb begin
    byte_nxt   = 8'd0;
    status_nxt = ST_BYTE;
    case (sub_r)
      2'd0:    byte_nxt = head_job.b0;
      2'd1:    byte_nxt = head_job.b1;
      2'd2:    byte_nxt = head_job.b2;
      default: byte_nxt = 8'd0;
    endcase
    if (sub_r >= head_job.nbytes) begin
      byte_nxt   = 8'd0;
      status_nxt = head_job.tail;
    end
    last_nxt = ({1'b0, sub_r} == total - 3'd1);
  end

  assign pop     = load && !empty && last_nxt;
  assign sub_nxt = last_nxt ? 2'd0 : sub_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 2'd0;
    end else if (load) begin
      valid_r <= !empty;
      if (!empty) begin
        sub_r <= sub_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      byte_r   <= byte_nxt;
      status_r <= status_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign out_byte     = byte_r;
  assign out_status   = status_r;
  assign out_run_last = last_r;

endmodule

// ----- hdl/json_string_unescaper.sv -----
// JSON string unescaper. Raw JSON text enters one byte per request together
// with a saturated count of the bytes that follow it; the block checks the
// opening quote, passes plain bytes, maps simple escapes, turns \uXXXX into
// one to three UTF-8 bytes and reports completion or one of six errors.
// Each input byte is handled by the front end as it is accepted: a new byte
// is accepted in every cycle while the four-entry job queue has room. The
// back end delivers one result per cycle from its output register while the
// receiver does not stall, so a byte that causes more than one result (up to
// four, for a three-byte UTF-8 sequence followed by an unterminated report)
// occupies the output until all of them are delivered; the queue absorbs
// such bursts, and the sustained input rate is one byte per cycle as long as
// results average no more than one per byte and the receiver does not stall.
module json_string_unescaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic [2:0] in_bytes_after,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_status,
  output logic       out_run_last
);
  import jsu_pkg::*;

  logic accept;
  logic job_valid;
  job_t job;
  job_t head_job;
  logic q_empty;
  logic q_full;
  logic pop;

  // The input is held off only when the queue is full. The full flag comes
  // from a register, so stall never depends on the incoming valid.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // The front end tracks the parsing phase and the hex accumulator, and turns
  // each accepted byte into a job that lists all results the byte causes.
  // Bytes that cause no result (the opening quote, a backslash, leading hex
  // digits) update the state and push nothing.
  jsu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .text_byte   (in_text_byte),
    .bytes_after (in_bytes_after),
    .job_valid   (job_valid),
    .job         (job)
  );

  // A short queue decouples the byte-per-cycle front end from the
  // result-per-cycle back end.
  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_job (job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // The back end walks the head job's results, one per cycle unless stalled,
  // marks the last one of each job and pops the job when that one is loaded.
  jsu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_job     (head_job),
    .empty        (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_status   (out_status),
    .out_run_last (out_run_last)
  );

endmodule

// ----- bench/unescape_check_pkg.sv -----
package unescape_check_pkg;
  import jsu_pkg::*;

  // ASCII codes that the decoder treats specially.
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_T       = 8'h74;

  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_CR  = 8'h0D;

  typedef struct {
    logic [7:0] data;
    status_t    status;
    logic       run_last;
  } decoded_t;

  class unescape_checker;
    phase_t      scan_phase;
    logic [1:0]  digit_count;
    logic [15:0] code_point;
    decoded_t    expected_out[$];
    decoded_t    caused[$];
    int          errors;

    function new();
      scan_phase  = PH_IDLE;
      digit_count = '0;
      code_point  = '0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_out.size();
    endfunction

    local function void emit(logic [7:0] d, status_t s);
      decoded_t r;
      r.data     = d;
      r.status   = s;
      r.run_last = 1'b0;
      caused.push_back(r);
    endfunction

    local function bit escape_byte(logic [7:0] c, output logic [7:0] m);
      m = 8'h00;
      case (c)
        CH_QUOTE, CH_BSLASH, CH_SLASH: m = c;
        CH_B: m = CTL_BS;
        CH_F: m = CTL_FF;
        CH_N: m = CTL_LF;
        CH_R: m = CTL_CR;
        CH_T: m = CTL_TAB;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    local function bit hex_nibble(logic [7:0] c, output logic [3:0] v);
      v = 4'h0;
      if (c >= CH_ZERO && c <= CH_NINE) v = 4'(c - CH_ZERO);
      else if (c >= CH_LOWER_A && c <= CH_LOWER_F) v = 4'(c - CH_LOWER_A + 8'd10);
      else if (c >= CH_UPPER_A && c <= CH_UPPER_F) v = 4'(c - CH_UPPER_A + 8'd10);
      else return 1'b0;
      return 1'b1;
    endfunction

    // Advances the decoder by one accepted byte and queues what it produces.
    function void note_request(logic [7:0] c, logic [2:0] remaining);
      logic       fin;
      logic [7:0] m;
      logic [3:0] v;
      caused.delete();
      fin = (remaining == 3'd0);
      case (scan_phase)
        PH_STR: begin
          if (c == CH_QUOTE) begin
            emit(8'h00, ST_DONE);
            scan_phase = PH_IDLE;
          end else if (c == CH_BSLASH) begin
            if (fin) begin
              emit(8'h00, ST_BADESC);
              scan_phase = PH_IDLE;
            end else begin
              scan_phase = PH_ESC;
            end
          end else begin
            emit(c, ST_BYTE);
            if (fin) begin
              emit(8'h00, ST_UNTERM);
              scan_phase = PH_IDLE;
            end
          end
        end
        PH_ESC: begin
          if (escape_byte(c, m)) begin
            emit(m, ST_BYTE);
            if (fin) begin
              emit(8'h00, ST_UNTERM);
              scan_phase = PH_IDLE;
            end else begin
              scan_phase = PH_STR;
            end
          end else if (c == CH_U) begin
            if (remaining < 3'd4) begin
              emit(8'h00, ST_SHORTU);
              scan_phase = PH_IDLE;
            end else begin
              digit_count = '0;
              code_point  = '0;
              scan_phase  = PH_HEX;
            end
          end else begin
            emit(8'h00, ST_UNKESC);
            scan_phase = PH_IDLE;
          end
        end
        PH_HEX: begin
          if (!hex_nibble(c, v)) begin
            emit(8'h00, ST_BADHEX);
            scan_phase = PH_IDLE;
          end else begin
            code_point = {code_point[11:0], v};
            if (digit_count != 2'd3) begin
              if (fin) begin
                emit(8'h00, ST_SHORTU);
                scan_phase = PH_IDLE;
              end else begin
                digit_count = digit_count + 2'd1;
              end
            end else begin
              // BMP code point to UTF-8; surrogates are encoded unchanged.
              if (code_point < 16'h0080) begin
                emit(code_point[7:0], ST_BYTE);
              end else if (code_point < 16'h0800) begin
                emit({3'b110, code_point[10:6]}, ST_BYTE);
                emit({2'b10, code_point[5:0]}, ST_BYTE);
              end else begin
                emit({4'b1110, code_point[15:12]}, ST_BYTE);
                emit({2'b10, code_point[11:6]}, ST_BYTE);
                emit({2'b10, code_point[5:0]}, ST_BYTE);
              end
              digit_count = '0;
              code_point  = '0;
              if (fin) begin
                emit(8'h00, ST_UNTERM);
                scan_phase = PH_IDLE;
              end else begin
                scan_phase = PH_STR;
              end
            end
          end
        end
        default: begin
          if (c == CH_QUOTE) begin
            if (fin) begin
              emit(8'h00, ST_UNTERM);
              scan_phase = PH_IDLE;
            end else begin
              scan_phase = PH_STR;
            end
          end else begin
            emit(8'h00, ST_QUOTE);
            scan_phase = PH_IDLE;
          end
        end
      endcase
      if (caused.size() != 0) begin
        caused[caused.size() - 1].run_last = 1'b1;
        foreach (caused[i]) expected_out.push_back(caused[i]);
      end
    endfunction

    function void check_result(logic [7:0] d, logic [2:0] s, logic l);
      decoded_t want;
      if (expected_out.size() == 0) begin
        $error("result with nothing expected: out_byte %02h out_status %0d out_run_last %0b",
               d, s, l);
        errors++;
        return;
      end
      want = expected_out.pop_front();
      if (d !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, d);
        errors++;
      end
      if (s !== want.status) begin
        $error("out_status: expected %0d, got %0d", want.status, s);
        errors++;
      end
      if (l !== want.run_last) begin
        $error("out_run_last: expected %0b, got %0b", want.run_last, l);
        errors++;
      end
    endfunction

    function void report_leftovers();
      if (expected_out.size() != 0) begin
        $error("%0d expected results never arrived", expected_out.size());
        errors += expected_out.size();
        expected_out.delete();
      end
    endfunction
  endclass

endpackage

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;
  import unescape_check_pkg::*;

  // Every input of the block starts at a known value.
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte = 8'h00;
  logic [2:0] in_bytes_after = 3'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] out_status;
  logic       out_run_last;

  unescape_checker board;

  // Knobs of the current traffic phase, as percentages of cycles.
  int idle_pct = 0;
  int stall_pct = 0;

  // A long receiver hold-off is requested by bumping hold_trigger; the
  // receiver process notices the change and counts the hold-off down itself.
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int sent = 0;
  logic [7:0] text_q[$];

  json_string_unescaper u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_bytes_after (in_bytes_after),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_status     (out_status),
    .out_run_last   (out_run_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog, set far beyond any legitimate end of the test.
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  // Both handshakes are observed at the rising edge, where inputs driven at
  // the falling edge are stable. The byte going in is noted before the result
  // coming out is checked, although the block's latency keeps them apart.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_request(in_text_byte, in_bytes_after);
      if (out_valid && !out_stall) board.check_result(out_byte, out_status, out_run_last);
    end
  end

  // Receiver side. It stalls at random according to the phase, or solidly
  // while a requested hold-off is still running.
  always @(negedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offers one byte as a request and returns at the falling edge after it was
  // taken. Valid is left high there, so the caller either offers the next
  // byte at once or lowers valid; it is never lowered and raised in one step.
  task automatic offer(logic [7:0] c, logic [2:0] remaining);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= c;
    in_bytes_after <= remaining;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    sent++;
  endtask

  // Sends the characters of txt with the byte counts spelled out in counts,
  // one decimal digit per character.
  task automatic drive_text(string txt, string counts);
    for (int i = 0; i < txt.len(); i++) offer(txt[i], 3'(counts[i] - CH_ZERO));
  endtask

  // The sender stops and waits until every predicted result has come out.
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
  endtask

  // Builds a short JSON text of one to three quoted strings. Most texts are
  // well formed so that the decoder gets deep into escapes and unicode
  // sequences; about one in four is then damaged by truncation, a replaced
  // byte or an inserted byte.
  task automatic build_text();
    int          pieces;
    logic [7:0]  c;
    logic [15:0] code;
    logic [3:0]  nib;
    text_q.delete();
    repeat ($urandom_range(1, 3)) begin
      text_q.push_back(CH_QUOTE);
      pieces = $urandom_range(0, 6);
      repeat (pieces) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            // Plain byte: printable half of the time, otherwise any value
            // that does not end the string or start an escape.
            do begin
              c = $urandom_range(1) ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom);
            end while (c == CH_QUOTE || c == CH_BSLASH);
            text_q.push_back(c);
          end
          4, 5, 6: begin
            text_q.push_back(CH_BSLASH);
            case ($urandom_range(7))
              0: text_q.push_back(CH_QUOTE);
              1: text_q.push_back(CH_BSLASH);
              2: text_q.push_back(CH_SLASH);
              3: text_q.push_back(CH_B);
              4: text_q.push_back(CH_F);
              5: text_q.push_back(CH_N);
              6: text_q.push_back(CH_R);
              default: text_q.push_back(CH_T);
            endcase
          end
          default: begin
            // Unicode escape, spread over the one, two and three byte
            // encodings with the range boundaries mixed in.
            case ($urandom_range(9))
              0, 1, 2: code = 16'($urandom_range(16'h0000, 16'h007F));
              3, 4, 5: code = 16'($urandom_range(16'h0080, 16'h07FF));
              6, 7, 8: code = 16'($urandom_range(16'h0800, 16'hFFFF));
              default: begin
                case ($urandom_range(5))
                  0: code = 16'h0000;
                  1: code = 16'h007F;
                  2: code = 16'h0080;
                  3: code = 16'h07FF;
                  4: code = 16'h0800;
                  default: code = 16'hFFFF;
                endcase
              end
            endcase
            text_q.push_back(CH_BSLASH);
            text_q.push_back(CH_U);
            for (int k = 3; k >= 0; k--) begin
              nib = code[4 * k +: 4];
              if (nib < 4'd10) text_q.push_back(CH_ZERO + 8'(nib));
              else if ($urandom_range(1)) text_q.push_back(CH_UPPER_A + 8'(nib) - 8'd10);
              else text_q.push_back(CH_LOWER_A + 8'(nib) - 8'd10);
            end
          end
        endcase
      end
      text_q.push_back(CH_QUOTE);
    end
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(2))
        0: repeat ($urandom_range(1, text_q.size() - 1)) void'(text_q.pop_back());
        1: text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom);
        default: text_q.insert($urandom_range(text_q.size()), 8'($urandom));
      endcase
    end
  endtask

  // Sends the built text with the saturated count of bytes that follow each
  // one. Now and then one count is replaced by a random value, which gives
  // the inconsistent counts that only a broken source would produce.
  task automatic send_text();
    int         fault_at;
    int         left;
    logic [2:0] remaining;
    fault_at = ($urandom_range(9) == 0) ? $urandom_range(text_q.size() - 1) : -1;
    for (int i = 0; i < text_q.size(); i++) begin
      left = text_q.size() - 1 - i;
      remaining = (left > 4) ? 3'd4 : 3'(left);
      if (i == fault_at) remaining = 3'($urandom_range(4));
      offer(text_q[i], remaining);
    end
  endtask

  initial begin
    int target;
    board = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests, with no idling on either side.
    offer(8'h00, 3'd4);                 // not a quote while waiting for a string
    drive_text("\"", "0");              // opening quote with nothing after it
    offer(CH_QUOTE, 3'd4);
    offer(8'hFF, 3'd0);                 // plain byte as the very last byte
    drive_text("\"\\t", "410");         // simple escape as the last byte
    drive_text("\"\\", "40");           // backslash as the last byte
    drive_text("\"\\z", "444");         // unknown escape letter
    drive_text("\"\\u", "433");         // too few bytes left for four hex digits
    drive_text("\"\\ug", "4443");       // a byte that is no hex digit
    drive_text("\"\\u7", "4440");       // text ends between hex digits
    drive_text("\"\\uFfFf", "4443210"); // fourth hex digit as the last byte
    wait_drained();

    // Random texts in several traffic phases. Each phase ends with the sender
    // paused until all predicted results have been delivered.
    for (int phase_no = 0; phase_no < 5; phase_no++) begin
      case (phase_no)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 65;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 65;
        end
        3: begin
          idle_pct  = 27;
          stall_pct = 27;
        end
        default: begin
          // The receiver holds off for a long stretch while bytes keep
          // coming, so the job queue fills and the input stalls.
          idle_pct  = 0;
          stall_pct = 20;
          hold_trigger++;
        end
      endcase
      target = sent + 30;
      while (sent < target) begin
        build_text();
        send_text();
      end
      wait_drained();
    end

    // Waiting on with the receiver unstalled catches any stray result after the last expected one.
    stall_pct = 0;
    repeat (8) @(negedge clk);
    board.report_leftovers();
    if (board.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
